// ===== sv/ovle_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ovle_pkg
// Shared types, command codes and status codes of the ordered value list
// engine.
// ----------------------------------------------------------------------------
package ovle_pkg;

  // Default number of list entries.
  localparam int unsigned DepthDefault = 16;

  // Command codes carried in the cmd field of an input item.
  localparam logic [2:0] CmdInsert = 3'd0;
  localparam logic [2:0] CmdSearch = 3'd1;
  localparam logic [2:0] CmdModify = 3'd2;
  localparam logic [2:0] CmdDelete = 3'd3;
  localparam logic [2:0] CmdPrint  = 3'd4;

  // Status codes carried in the status field of a result item.
  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StEmpty    = 2'd2;
  localparam logic [1:0] StFull     = 2'd3;

  // Input item.
  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] key;
    logic signed [31:0] new_value;
  } ovle_in_t;

  // Result item.
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] entry_value;
    logic               last;
  } ovle_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;        // capture a new input item and rewind the pointer
    logic       step;        // read the entry under the pointer and advance
    logic       seek;        // move the pointer just past the matched entry
    logic       shift_wr;    // write the last read entry one slot toward the head
    logic       wr_mod;      // overwrite the matched entry with new_value
    logic       ins;         // append new_value at the tail
    logic       dec;         // drop one entry from the count
    logic       emit;        // load the output register
    logic       emit_entry;  // emitted value comes from the last read entry
    logic       emit_last;
    logic [1:0] emit_status;
  } ovle_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] op;         // command of the item being worked on
    logic       full;
    logic       empty;
    logic       match;      // last read entry equals the key
    logic       exhausted;  // no read pending and pointer at the tail
    logic       at_end;     // pointer sits at the tail
    logic       out_free;   // output register can take a result this cycle
  } ovle_sts_t;

endpackage
`default_nettype wire

// ===== sv/ovle_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ovle_dp
// Datapath of the list engine: entry memory with a registered read port,
// entry count, scan pointer, key compare and the output register.
// ----------------------------------------------------------------------------
module ovle_dp #(
  parameter int unsigned DEPTH = ovle_pkg::DepthDefault
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  ovle_pkg::ovle_in_t  in_data_i,
  input  ovle_pkg::ovle_cmd_t cmd_i,
  output ovle_pkg::ovle_sts_t sts_o,
  input  wire                 out_ready_i,
  output logic                out_valid_o,
  output ovle_pkg::ovle_out_t out_data_o
);
  import ovle_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Entry memory, undefined until written.
  logic signed [31:0] mem [DEPTH];

  logic [2:0]         op_q;
  logic signed [31:0] key_q;
  logic signed [31:0] nv_q;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic          rd_vld_q, rd_vld_d;
  logic [AW-1:0] rd_idx_q;
  logic signed [31:0] rd_data_q;

  logic          rd_en;
  logic          ptr_in_list;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic signed [31:0] wr_data;

  logic      out_vld_q, out_vld_d;
  ovle_out_t out_q;
  logic      out_free;

  // Captured input item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= in_data_i.cmd;
      key_q <= in_data_i.key;
      nv_q  <= in_data_i.new_value;
    end
  end

  // A read step only fetches positions below the entry count.
  assign ptr_in_list = (ptr_q < count_q);
  assign rd_en       = cmd_i.step && ptr_in_list;

  // Pointer and read-valid tracking.
  always_comb begin
    ptr_d    = ptr_q;
    rd_vld_d = rd_vld_q;
    priority if (cmd_i.load) begin
      ptr_d    = '0;
      rd_vld_d = 1'b0;
    end else if (cmd_i.seek) begin
      ptr_d    = CW'(rd_idx_q) + CW'(1);
      rd_vld_d = 1'b0;
    end else if (cmd_i.step) begin
      if (ptr_in_list) begin
        ptr_d = ptr_q + CW'(1);
      end
      rd_vld_d = ptr_in_list;
    end
  end

  // Entry count.
  always_comb begin
    count_d = count_q;
    priority if (cmd_i.ins) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.dec) begin
      count_d = count_q - CW'(1);
    end
  end

  // Single write port: append, overwrite or compaction move.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_q[AW-1:0];
    wr_data = nv_q;
    priority if (cmd_i.ins) begin
      wr_en   = 1'b1;
      wr_addr = count_q[AW-1:0];
      wr_data = nv_q;
    end else if (cmd_i.wr_mod) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx_q;
      wr_data = nv_q;
    end else if (cmd_i.shift_wr && rd_vld_q) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx_q - AW'(1);
      wr_data = rd_data_q;
    end
  end

  // Memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[ptr_q[AW-1:0]];
      rd_idx_q  <= ptr_q[AW-1:0];
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      ptr_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      ptr_q     <= ptr_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Output register: free when empty or being taken this cycle.
  assign out_free = !out_vld_q || out_ready_i;

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_i.emit) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.status      <= cmd_i.emit_status;
      out_q.entry_value <= cmd_i.emit_entry ? rd_data_q : 32'sd0;
      out_q.last        <= cmd_i.emit_last;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Status toward the controller.
  assign sts_o.op        = op_q;
  assign sts_o.full      = (count_q == CW'(DEPTH));
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.match     = rd_vld_q && (rd_data_q == key_q);
  assign sts_o.exhausted = !rd_vld_q && (ptr_q == count_q);
  assign sts_o.at_end    = (ptr_q == count_q);
  assign sts_o.out_free  = out_free;

endmodule
`default_nettype wire

// ===== sv/ovle_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ovle_ctrl
// Controller of the list engine: sequences dispatch, scan, compaction,
// print and the final result of each known command.
// ----------------------------------------------------------------------------
module ovle_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  ovle_pkg::ovle_sts_t sts_i,
  output ovle_pkg::ovle_cmd_t cmd_o
);
  import ovle_pkg::*;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SDisp  = 3'd1;
  localparam logic [2:0] SScan  = 3'd2;
  localparam logic [2:0] SShift = 3'd3;
  localparam logic [2:0] SPrint = 3'd4;
  localparam logic [2:0] SFin   = 3'd5;

  logic [2:0] state_q, state_d;
  logic [1:0] st_q, st_d;

  assign in_ready_o = (state_q == SIdle);

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    cmd_o   = '0;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = SDisp;
        end
      end
      SDisp: begin
        unique case (sts_i.op)
          CmdInsert: begin
            if (sts_i.full) begin
              st_d = StFull;
            end else begin
              cmd_o.ins = 1'b1;
              st_d      = StOk;
            end
            state_d = SFin;
          end
          CmdSearch, CmdModify, CmdDelete, CmdPrint: begin
            if (sts_i.empty) begin
              st_d    = StEmpty;
              state_d = SFin;
            end else begin
              cmd_o.step = 1'b1;
              state_d    = (sts_i.op == CmdPrint) ? SPrint : SScan;
            end
          end
          default: begin
            // Unknown commands give no result.
            state_d = SIdle;
          end
        endcase
      end
      SScan: begin
        priority if (sts_i.match) begin
          st_d = StOk;
          unique case (sts_i.op)
            CmdModify: begin
              cmd_o.wr_mod = 1'b1;
              state_d      = SFin;
            end
            CmdDelete: begin
              cmd_o.seek = 1'b1;
              state_d    = SShift;
            end
            default: begin
              state_d = SFin;
            end
          endcase
        end else if (sts_i.exhausted) begin
          st_d    = StNotFound;
          state_d = SFin;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      SShift: begin
        // Move every entry behind the removed one a slot toward the head.
        if (sts_i.exhausted) begin
          cmd_o.dec = 1'b1;
          st_d      = StOk;
          state_d   = SFin;
        end else begin
          cmd_o.step     = 1'b1;
          cmd_o.shift_wr = 1'b1;
        end
      end
      SPrint: begin
        if (sts_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_entry  = 1'b1;
          cmd_o.emit_status = StOk;
          cmd_o.emit_last   = sts_i.at_end;
          if (sts_i.at_end) begin
            state_d = SIdle;
          end else begin
            cmd_o.step = 1'b1;
          end
        end
      end
      SFin: begin
        if (sts_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = st_q;
          cmd_o.emit_last   = 1'b1;
          state_d           = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      st_q    <= StOk;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ordered_value_list_engine_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_value_list_engine_core
// Insertion-ordered list of up to DEPTH signed 32-bit values with insert,
// search, modify, delete and print commands.
// ----------------------------------------------------------------------------
// One item is worked on at a time; the input is ready only between items.
// All entries sit in one memory with one read and one write port, and the
// read port sets the timing. A search or modify scans from the head up to
// its first match, or over every entry on a miss. A delete scans up to its
// match and then reads every later entry and writes it back one slot toward
// the head. A print gives one item per cycle as long as the output is taken.
// A finished result waits in an output register and holds off only the next
// result, not the work leading up to it.
// ----------------------------------------------------------------------------
module ordered_value_list_engine_core #(
  parameter int unsigned DEPTH = ovle_pkg::DepthDefault
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  ovle_pkg::ovle_in_t  in_data_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output ovle_pkg::ovle_out_t out_data_o
);
  import ovle_pkg::*;

  ovle_cmd_t dp_cmd;
  ovle_sts_t dp_sts;

  // Controller.
  ovle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  // Datapath.
  ovle_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // A result is loaded only when the output register can take it.
  a_emit_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.emit |-> dp_sts.out_free)
    else $error("result loaded while output register was occupied");

  // An append never happens on a full list.
  a_no_insert_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.ins |-> !dp_sts.full)
    else $error("append issued on a full list");

  // At most one source drives the memory write port.
  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({dp_cmd.ins, dp_cmd.wr_mod, dp_cmd.shift_wr}))
    else $error("more than one memory write source active");

  // An accepted item closes the input until its work is done.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input ready right after an item was accepted");

endmodule
`default_nettype wire

// ===== test/tb_ordered_value_list_engine_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ordered_value_list_engine_core
// Self-checking bench for the ordered value list engine. A directed stimulus
// table covers the empty list, the extremes of the values, duplicates, the
// sole-entry delete and the unknown commands. A fill-and-overflow pass covers
// the full list. Random command streams then follow, with keys mostly drawn
// from the stored entries. Every result is checked against a typed row's
// expected result or else against a shadow copy of the list kept in the bench.
// ----------------------------------------------------------------------------
module tb_ordered_value_list_engine_core;
  import ovle_pkg::*;

  localparam int unsigned DEPTH = DepthDefault;
  localparam int RandItems = 310;
  localparam int PhaseItems = 40;
  localparam int TailCycles = 40;

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  ovle_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  ovle_out_t out_data;

  // Shadow copy of the list and the results it still owes.
  logic signed [31:0] shadow_entries [DEPTH];
  int                 shadow_count = 0;
  ovle_out_t          step_results [$];
  ovle_out_t          pending_results [$];

  // Directed stimulus rows; typed rows carry their one expected result.
  typedef struct {
    ovle_in_t  item;
    bit        typed;
    ovle_out_t want;
  } stim_row_t;
  stim_row_t stim_rows [$];

  int  errors = 0;
  int  items_sent = 0;
  int  results_checked = 0;
  int  print_results = 0;
  int  full_hits = 0;
  int  empty_hits = 0;
  int  miss_hits = 0;
  int  sink_hold = 0;
  bit  quiet_mode = 1'b0;

  ordered_value_list_engine_core #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #12_000_000;
    $display("FAILURE");
    $finish;
  end

  // Mostly short bursts, now and then a long one.
  function automatic int burst_len();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic int sender_gap();
    if (quiet_mode || $urandom_range(0, 99) < 50) begin
      return 0;
    end
    return burst_len();
  endfunction

  // Applies one command to the shadow list and leaves its results in
  // step_results.
  function automatic void shadow_step(input ovle_in_t item);
    ovle_out_t r;
    int        pos;
    int        i;
    step_results.delete();
    r.status      = StOk;
    r.entry_value = '0;
    r.last        = 1'b1;
    if (item.cmd > CmdPrint) begin
      return;
    end
    if (item.cmd == CmdInsert) begin
      if (shadow_count >= DEPTH) begin
        r.status = StFull;
        full_hits++;
      end else begin
        shadow_entries[shadow_count] = item.new_value;
        shadow_count++;
      end
      step_results.push_back(r);
      return;
    end
    if (shadow_count == 0) begin
      r.status = StEmpty;
      empty_hits++;
      step_results.push_back(r);
      return;
    end
    if (item.cmd == CmdPrint) begin
      for (i = 0; i < shadow_count; i++) begin
        r.entry_value = shadow_entries[i];
        r.last        = (i == shadow_count - 1);
        step_results.push_back(r);
      end
      print_results += shadow_count;
      return;
    end
    // Search, modify and delete act on the first match from the head.
    pos = -1;
    for (i = 0; i < shadow_count; i++) begin
      if (pos < 0 && shadow_entries[i] == item.key) begin
        pos = i;
      end
    end
    if (pos < 0) begin
      r.status = StNotFound;
      miss_hits++;
    end else if (item.cmd == CmdModify) begin
      shadow_entries[pos] = item.new_value;
    end else if (item.cmd == CmdDelete) begin
      for (i = pos; i + 1 < shadow_count; i++) begin
        shadow_entries[i] = shadow_entries[i + 1];
      end
      shadow_count--;
    end
    step_results.push_back(r);
  endfunction

  function automatic ovle_in_t make_item(input logic [2:0] cmd, input logic [31:0] key,
                                         input logic [31:0] new_value);
    ovle_in_t item;
    item.cmd       = cmd;
    item.key       = key;
    item.new_value = new_value;
    return item;
  endfunction

  function automatic void add_row(input logic [2:0] cmd, input logic [31:0] key,
                                  input logic [31:0] new_value, input bit typed,
                                  input logic [1:0] status);
    stim_row_t row;
    row.item             = make_item(cmd, key, new_value);
    row.typed            = typed;
    row.want.status      = status;
    row.want.entry_value = '0;
    row.want.last        = 1'b1;
    stim_rows.push_back(row);
  endfunction

  // Key that hits a stored entry most of the time.
  function automatic logic [31:0] pick_key();
    if (shadow_count > 0 && $urandom_range(0, 99) < 65) begin
      return shadow_entries[$urandom_range(0, shadow_count - 1)];
    end
    return $urandom;
  endfunction

  // Value with some duplicates and extremes mixed in.
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20 && shadow_count > 0) begin
      return shadow_entries[$urandom_range(0, shadow_count - 1)];
    end
    if (r < 24) begin
      return 32'h8000_0000;
    end
    if (r < 28) begin
      return 32'h7fff_ffff;
    end
    return $urandom;
  endfunction

  // Random command; mode 0 leans to filling, 1 to draining, 2 is mixed.
  function automatic ovle_in_t random_item(input int mode);
    int         r;
    int         w_ins;
    int         w_del;
    logic [2:0] cmd;
    w_ins = (mode == 0) ? 55 : (mode == 1) ? 15 : 30;
    w_del = (mode == 0) ? 10 : (mode == 1) ? 50 : 25;
    r = $urandom_range(0, 99);
    if (r < w_ins) begin
      cmd = CmdInsert;
    end else if (r < w_ins + w_del) begin
      cmd = CmdDelete;
    end else if (r < 95) begin
      case ($urandom_range(0, 6))
        0, 1, 2: cmd = CmdSearch;
        3, 4:    cmd = CmdModify;
        default: cmd = CmdPrint;
      endcase
    end else begin
      cmd = 3'($urandom_range(5, 7));
    end
    return make_item(cmd, pick_key(), pick_value());
  endfunction

  // Offers one item and waits for it to be taken. The valid stays high into
  // the next item when no gap is drawn.
  task automatic send_item(input ovle_in_t item, input bit typed, input ovle_out_t want);
    int gap;
    int i;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (!in_ready);
    items_sent++;
    shadow_step(item);
    if (typed) begin
      pending_results.push_back(want);
    end else begin
      for (i = 0; i < step_results.size(); i++) begin
        pending_results.push_back(step_results[i]);
      end
    end
  endtask

  task automatic send_checked(input ovle_in_t item);
    send_item(item, 1'b0, '0);
  endtask

  // Holds the sender off until every owed result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Receiver stalls.
  always @(posedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold--;
      out_ready <= 1'b0;
    end else if (!quiet_mode && $urandom_range(0, 99) < 18) begin
      sink_hold = burst_len() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    ovle_out_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: status %0d value %h last %b", $time,
                 out_data.status, out_data.entry_value, out_data.last);
        errors++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_data.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                   want.status, out_data.status);
          errors++;
        end
        if (out_data.entry_value !== want.entry_value) begin
          $display("%0t: entry_value mismatch: expected %h, actual %h", $time,
                   want.entry_value, out_data.entry_value);
          errors++;
        end
        if (out_data.last !== want.last) begin
          $display("%0t: last mismatch: expected %b, actual %b", $time,
                   want.last, out_data.last);
          errors++;
        end
      end
    end
  end

  // Stimulus.
  initial begin
    int       n;
    int       k;
    int       phase;
    int       mode;
    int       sent;
    ovle_in_t item;

    // Directed rows: empty list, sole-entry delete, extremes, duplicates.
    add_row(CmdSearch, 32'h0, 32'h0, 1'b1, StEmpty);
    add_row(CmdModify, 32'hffff_ffff, 32'h1, 1'b1, StEmpty);
    add_row(CmdDelete, 32'h8000_0000, 32'h0, 1'b1, StEmpty);
    add_row(CmdPrint, 32'h0, 32'h0, 1'b1, StEmpty);
    add_row(3'd5, 32'hffff_ffff, 32'hffff_ffff, 1'b0, StOk);
    add_row(CmdInsert, 32'h0, 32'h9, 1'b1, StOk);
    add_row(CmdDelete, 32'h9, 32'h0, 1'b1, StOk);
    add_row(CmdSearch, 32'h9, 32'h0, 1'b1, StEmpty);
    add_row(CmdInsert, 32'hffff_ffff, 32'h8000_0000, 1'b1, StOk);
    add_row(CmdInsert, 32'h0, 32'h7fff_ffff, 1'b1, StOk);
    add_row(CmdInsert, 32'h0, 32'hffff_ffff, 1'b1, StOk);
    add_row(CmdInsert, 32'h0, 32'h7fff_ffff, 1'b1, StOk);
    add_row(CmdInsert, 32'h0, 32'h0, 1'b1, StOk);
    add_row(CmdPrint, 32'h0, 32'h0, 1'b0, StOk);
    add_row(CmdSearch, 32'h7fff_ffff, 32'h0, 1'b1, StOk);
    add_row(CmdSearch, 32'h1234, 32'h0, 1'b1, StNotFound);
    add_row(CmdModify, 32'h7fff_ffff, 32'h8000_0000, 1'b1, StOk);
    add_row(CmdModify, 32'h55, 32'h1, 1'b1, StNotFound);
    add_row(CmdDelete, 32'h2, 32'h0, 1'b1, StNotFound);
    add_row(3'd6, 32'h0, 32'h0, 1'b0, StOk);
    add_row(CmdDelete, 32'h8000_0000, 32'h0, 1'b1, StOk);
    add_row(CmdPrint, 32'h0, 32'h0, 1'b0, StOk);
    add_row(3'd7, 32'h7fff_ffff, 32'h8000_0000, 1'b0, StOk);
    add_row(CmdSearch, 32'h8000_0000, 32'h0, 1'b1, StOk);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (n = 0; n < stim_rows.size(); n++) begin
      send_item(stim_rows[n].item, stim_rows[n].typed, stim_rows[n].want);
    end

    // Fill to the top, overflow once, print it all, then probe both ends.
    while (shadow_count < DEPTH) begin
      send_checked(make_item(CmdInsert, $urandom, $urandom));
    end
    send_checked(make_item(CmdInsert, 32'h0, 32'h7fff_ffff));
    send_checked(make_item(CmdPrint, 32'h0, 32'h0));
    send_checked(make_item(CmdSearch, shadow_entries[DEPTH - 1], 32'h0));
    send_checked(make_item(CmdModify, shadow_entries[DEPTH - 1], 32'h8000_0000));
    send_checked(make_item(CmdDelete, shadow_entries[0], 32'h0));
    send_checked(make_item(CmdDelete, shadow_entries[shadow_count - 1], 32'h0));
    wait_drained();

    // Random phases, most leaning one way, some without any idling.
    sent = 0;
    for (phase = 0; sent < RandItems; phase++) begin
      mode = $urandom_range(0, 2);
      quiet_mode <= ($urandom_range(0, 4) == 0);
      if (phase == 1 || $urandom_range(0, 3) == 0) begin
        wait_drained();
      end
      for (k = 0; k < PhaseItems && sent < RandItems; k++) begin
        item = random_item(mode);
        send_checked(item);
        if (item.cmd <= CmdPrint) begin
          sent++;
        end
      end
    end

    // Wind down: collect everything, then watch for stray results.
    in_valid <= 1'b0;
    quiet_mode <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Covered %0d items and %0d results, %0d of them from print.",
             items_sent, results_checked, print_results);
    $display("Full list %0d times, empty list %0d times, no match %0d times.",
             full_hits, empty_hits, miss_hits);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
